/* rtl/core/sqltl_pkg.sv */
`timescale 1ns / 1ps
// Package for the SQL token lexer: kind and mode codes, byte constants,
// result item type, keyword table and token helper functions. No dependencies.
package sqltl_pkg;

   localparam int PosWidth   = 16;
   localparam int QueueDepth = 8;
   localparam int QueueAw    = $clog2(QueueDepth);
   localparam int MaxResults = 3;

   localparam logic [5:0] K_END     = 6'd0;
   localparam logic [5:0] K_ERROR   = 6'd1;
   localparam logic [5:0] K_IDENT   = 6'd2;
   localparam logic [5:0] K_NUMBER  = 6'd3;
   localparam logic [5:0] K_STRING  = 6'd4;
   localparam logic [5:0] K_STAR    = 6'd5;
   localparam logic [5:0] K_LPAREN  = 6'd6;
   localparam logic [5:0] K_RPAREN  = 6'd7;
   localparam logic [5:0] K_COMMA   = 6'd8;
   localparam logic [5:0] K_SEMI    = 6'd9;
   localparam logic [5:0] K_EQ      = 6'd10;
   localparam logic [5:0] K_LT      = 6'd11;
   localparam logic [5:0] K_LE      = 6'd12;
   localparam logic [5:0] K_NE      = 6'd13;
   localparam logic [5:0] K_GT      = 6'd14;
   localparam logic [5:0] K_GE      = 6'd15;
   localparam logic [5:0] K_CONTENT = 6'd46;

   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_LT     = 4'd1;
   localparam logic [3:0] M_GT     = 4'd2;
   localparam logic [3:0] M_BANG   = 4'd3;
   localparam logic [3:0] M_MINUS  = 4'd4;
   localparam logic [3:0] M_NUMBER = 4'd5;
   localparam logic [3:0] M_WORD   = 4'd6;
   localparam logic [3:0] M_STRING = 4'd7;
   localparam logic [3:0] M_ESC    = 4'd8;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [63:0] NumLimPos = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NumLimNeg = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [5:0]         kind;
      logic [15:0]        start_pos;
      logic [15:0]        span_len;
      logic signed [63:0] num_value;
      logic               num_overflow;
      logic [7:0]         char_out;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [55:0] text;
      logic [5:0]  kind;
   } keyword_type;

   function automatic keyword_type kw_entry(input logic [4:0] idx);
      keyword_type e;
      logic [55:0] lit;
      e = '0;
      lit = '0;
      case (idx)
         5'd0:  begin e.len = 3'd6; lit = 56'("CREATE");  e.kind = 6'd16; end
         5'd1:  begin e.len = 3'd5; lit = 56'("TABLE");   e.kind = 6'd17; end
         5'd2:  begin e.len = 3'd6; lit = 56'("INSERT");  e.kind = 6'd18; end
         5'd3:  begin e.len = 3'd4; lit = 56'("INTO");    e.kind = 6'd19; end
         5'd4:  begin e.len = 3'd6; lit = 56'("VALUES");  e.kind = 6'd20; end
         5'd5:  begin e.len = 3'd6; lit = 56'("SELECT");  e.kind = 6'd21; end
         5'd6:  begin e.len = 3'd4; lit = 56'("FROM");    e.kind = 6'd22; end
         5'd7:  begin e.len = 3'd5; lit = 56'("WHERE");   e.kind = 6'd23; end
         5'd8:  begin e.len = 3'd3; lit = 56'("AND");     e.kind = 6'd24; end
         5'd9:  begin e.len = 3'd2; lit = 56'("OR");      e.kind = 6'd25; end
         5'd10: begin e.len = 3'd3; lit = 56'("NOT");     e.kind = 6'd26; end
         5'd11: begin e.len = 3'd6; lit = 56'("DELETE");  e.kind = 6'd27; end
         5'd12: begin e.len = 3'd4; lit = 56'("DROP");    e.kind = 6'd28; end
         5'd13: begin e.len = 3'd5; lit = 56'("INDEX");   e.kind = 6'd29; end
         5'd14: begin e.len = 3'd2; lit = 56'("ON");      e.kind = 6'd30; end
         5'd15: begin e.len = 3'd5; lit = 56'("ORDER");   e.kind = 6'd31; end
         5'd16: begin e.len = 3'd2; lit = 56'("BY");      e.kind = 6'd32; end
         5'd17: begin e.len = 3'd3; lit = 56'("ASC");     e.kind = 6'd33; end
         5'd18: begin e.len = 3'd4; lit = 56'("DESC");    e.kind = 6'd34; end
         5'd19: begin e.len = 3'd3; lit = 56'("SET");     e.kind = 6'd35; end
         5'd20: begin e.len = 3'd6; lit = 56'("UPDATE");  e.kind = 6'd36; end
         5'd21: begin e.len = 3'd3; lit = 56'("INT");     e.kind = 6'd37; end
         5'd22: begin e.len = 3'd7; lit = 56'("INTEGER"); e.kind = 6'd37; end
         5'd23: begin e.len = 3'd7; lit = 56'("VARCHAR"); e.kind = 6'd38; end
         5'd24: begin e.len = 3'd4; lit = 56'("TEXT");    e.kind = 6'd39; end
         5'd25: begin e.len = 3'd4; lit = 56'("BOOL");    e.kind = 6'd40; end
         5'd26: begin e.len = 3'd7; lit = 56'("BOOLEAN"); e.kind = 6'd40; end
         5'd27: begin e.len = 3'd4; lit = 56'("TRUE");    e.kind = 6'd41; end
         5'd28: begin e.len = 3'd5; lit = 56'("FALSE");   e.kind = 6'd42; end
         5'd29: begin e.len = 3'd4; lit = 56'("NULL");    e.kind = 6'd43; end
         5'd30: begin e.len = 3'd7; lit = 56'("PRIMARY"); e.kind = 6'd44; end
         default: begin e.len = 3'd3; lit = 56'("KEY");   e.kind = 6'd45; end
      endcase
      // first character goes to the low byte
      for (int j = 0; j < 7; j++) begin
         if (j < int'(e.len)) begin
            e.text[8*j +: 8] = lit[8*(int'(e.len) - 1 - j) +: 8];
         end
      end
      return e;
   endfunction

   function automatic logic [5:0] word_kind(input logic [55:0] wbuf, input logic [3:0] wlen);
      logic [5:0]  k;
      keyword_type e;
      k = K_IDENT;
      for (int i = 31; i >= 0; i--) begin
         e = kw_entry(5'(i));
         if (wlen == {1'b0, e.len} && wbuf == e.text) begin
            k = e.kind;
         end
      end
      return k;
   endfunction

   function automatic result_type mk_item(input logic [5:0] kind,
                                          input logic [PosWidth-1:0] start,
                                          input logic [PosWidth-1:0] span,
                                          input logic [7:0] ch);
      result_type r;
      r = '0;
      r.kind      = kind;
      r.start_pos = 16'(start);
      r.span_len  = 16'(span);
      r.char_out  = ch;
      return r;
   endfunction

   function automatic result_type finish_item(input logic [3:0] mode,
                                              input logic [PosWidth-1:0] ts,
                                              input logic [PosWidth-1:0] end_p,
                                              input logic [63:0] acc,
                                              input logic neg,
                                              input logic ovf,
                                              input logic [55:0] wbuf,
                                              input logic [3:0] wlen);
      result_type r;
      logic [PosWidth-1:0] span;
      span = end_p - ts;
      r = mk_item(K_ERROR, ts, span, 8'd0);
      case (mode) inside
         M_LT:     r.kind = K_LT;
         M_GT:     r.kind = K_GT;
         M_BANG:   r.char_out = CH_BANG;
         M_MINUS:  r.char_out = CH_MINUS;
         M_NUMBER: begin
            r.kind         = K_NUMBER;
            r.num_value    = neg ? -acc : acc;
            r.num_overflow = ovf;
         end
         M_WORD:   r.kind = word_kind(wbuf, wlen);
         M_STRING, M_ESC: r.kind = K_STRING;
         default:  r.kind = K_ERROR;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/sqltl_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the SQL token lexer: query byte items in, token items out.
// No dependencies.
interface sqltl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface sqltl_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         kind;
   logic [15:0]        start_pos;
   logic [15:0]        span_len;
   logic signed [63:0] num_value;
   logic               num_overflow;
   logic [7:0]         char_out;
   logic               last_of_run;
   modport source (output valid, kind, start_pos, span_len, num_value, num_overflow,
                   char_out, last_of_run, input ready);
   modport sink   (input valid, kind, start_pos, span_len, num_value, num_overflow,
                   char_out, last_of_run, output ready);
endinterface

/* rtl/core/sql_token_lexer_unit.sv */
`timescale 1ns / 1ps
// SQL token lexer top level: lexer state, per-byte token logic, result queue.
// Depends on sqltl_pkg and the channel interfaces in sqltl_if.sv.
//
// Usage:
//   req_chan carries one query byte per item with in_last on the final byte.
//   rsp_chan carries token items; one byte gives zero to three of them, and
//   last_of_run marks the final item caused by a byte. After the last byte
//   the END item follows and the lexer starts over at offset zero.
//   A byte is lexed in its accept cycle; its items are written into an 8-entry queue
//   register, and rsp_chan is driven from the head of that queue.
//   Throughput: one byte per cycle while the queue has room for three items;
//   the queue drains one item per cycle while rsp_chan.ready is high, so runs
//   of multi-item bytes slow the input to the output rate.
//   Reset clears the lexer state and empties the queue; no items are pending.
//   When the receiver stalls, items collect in the queue and req_chan.ready
//   drops once fewer than three slots are free.
module sql_token_lexer_unit (
   input  logic               clock,
   input  logic               reset,
   sqltl_req_if.sink          req_chan,
   sqltl_rsp_if.source        rsp_chan
);

   localparam int Pw = sqltl_pkg::PosWidth;
   localparam int Aw = sqltl_pkg::QueueAw;

   logic [3:0]    mode_ff,  mode_in;
   logic [Pw-1:0] pos_ff,   pos_in;
   logic [Pw-1:0] tstart_ff, tstart_in;
   logic [55:0]   wbuf_ff,  wbuf_in;
   logic [3:0]    wlen_ff,  wlen_in;
   logic [63:0]   acc_ff,   acc_in;
   logic          neg_ff,   neg_in;
   logic          ovf_ff,   ovf_in;

   sqltl_pkg::result_type queue_ff [sqltl_pkg::QueueDepth];
   logic [Aw-1:0] wptr_ff, wptr_in;
   logic [Aw-1:0] rptr_ff, rptr_in;
   logic [Aw:0]   count_ff, count_in;

   sqltl_pkg::result_type res [sqltl_pkg::MaxResults];
   logic [1:0]    nres;
   logic          take, give;

   logic [7:0]    b;
   logic [7:0]    ub;
   logic [Pw-1:0] p1;
   logic          is_dig, is_alpha, do_fin, do_start, add_en;
   logic [67:0]   acc_x10;
   logic [63:0]   lim;

   assign take = req_chan.valid && req_chan.ready;
   assign give = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = count_ff <= (Aw+1)'(sqltl_pkg::QueueDepth - sqltl_pkg::MaxResults);

   assign b        = req_chan.in_byte;
   assign is_dig   = b >= 8'h30 && b <= 8'h39;
   assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   assign ub       = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
   assign p1       = pos_ff + Pw'(1);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      wbuf_in   = wbuf_ff;
      wlen_in   = wlen_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      res       = '{default: '0};
      nres      = 2'd0;
      do_fin    = 1'b0;
      do_start  = 1'b0;
      add_en    = 1'b0;
      acc_x10   = '0;
      lim       = '0;

      unique case (mode_ff)
         sqltl_pkg::M_LT: begin
            if (b == sqltl_pkg::CH_EQ) begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_LE, tstart_ff, Pw'(2), 8'd0);
               nres = nres + 2'd1;
               mode_in = sqltl_pkg::M_IDLE;
            end else if (b == sqltl_pkg::CH_GT) begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_NE, tstart_ff, Pw'(2), 8'd0);
               nres = nres + 2'd1;
               mode_in = sqltl_pkg::M_IDLE;
            end else begin
               do_fin = 1'b1;
               do_start = 1'b1;
            end
         end
         sqltl_pkg::M_GT, sqltl_pkg::M_BANG: begin
            if (b == sqltl_pkg::CH_EQ) begin
               res[nres] = sqltl_pkg::mk_item(
                  (mode_ff == sqltl_pkg::M_GT) ? sqltl_pkg::K_GE : sqltl_pkg::K_NE,
                  tstart_ff, Pw'(2), 8'd0);
               nres = nres + 2'd1;
               mode_in = sqltl_pkg::M_IDLE;
            end else begin
               do_fin = 1'b1;
               do_start = 1'b1;
            end
         end
         sqltl_pkg::M_MINUS: begin
            if (is_dig) begin
               mode_in = sqltl_pkg::M_NUMBER;
               neg_in  = 1'b1;
               ovf_in  = 1'b0;
               acc_in  = '0;
               add_en  = 1'b1;
            end else begin
               do_fin = 1'b1;
               do_start = 1'b1;
            end
         end
         sqltl_pkg::M_NUMBER: begin
            if (is_dig) begin
               add_en = 1'b1;
            end else begin
               do_fin = 1'b1;
               do_start = 1'b1;
            end
         end
         sqltl_pkg::M_WORD: begin
            if (is_alpha || is_dig || b == sqltl_pkg::CH_UNDER) begin
               if (wlen_ff < 4'd7) begin
                  wbuf_in[{wlen_ff[2:0], 3'b000} +: 8] = ub;
               end
               if (wlen_ff < 4'd8) begin
                  wlen_in = wlen_ff + 4'd1;
               end
            end else begin
               do_fin = 1'b1;
               do_start = 1'b1;
            end
         end
         sqltl_pkg::M_STRING: begin
            if (b == sqltl_pkg::CH_QUOTE) begin
               res[nres] = sqltl_pkg::finish_item(mode_ff, tstart_ff, p1, acc_ff, neg_ff,
                                                  ovf_ff, wbuf_ff, wlen_ff);
               nres = nres + 2'd1;
               mode_in = sqltl_pkg::M_IDLE;
            end else if (b == sqltl_pkg::CH_BSLASH) begin
               mode_in = sqltl_pkg::M_ESC;
            end else begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_CONTENT, pos_ff, Pw'(1), b);
               nres = nres + 2'd1;
            end
         end
         sqltl_pkg::M_ESC: begin
            res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_CONTENT, pos_ff - Pw'(1), Pw'(2), b);
            nres = nres + 2'd1;
            mode_in = sqltl_pkg::M_STRING;
         end
         default: begin
            mode_in = sqltl_pkg::M_IDLE;
            do_start = 1'b1;
         end
      endcase

      if (do_fin) begin
         res[nres] = sqltl_pkg::finish_item(mode_ff, tstart_ff, pos_ff, acc_ff, neg_ff,
                                            ovf_ff, wbuf_ff, wlen_ff);
         nres = nres + 2'd1;
         mode_in = sqltl_pkg::M_IDLE;
      end

      if (do_start) begin
         tstart_in = pos_ff;
         case (b) inside
            sqltl_pkg::CH_SPACE, sqltl_pkg::CH_TAB, sqltl_pkg::CH_LF, sqltl_pkg::CH_CR: ;
            sqltl_pkg::CH_STAR: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_STAR, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_LPAREN: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_LPAREN, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_RPAREN: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_RPAREN, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_COMMA: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_COMMA, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_SEMI: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_SEMI, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_EQ: begin
               res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_EQ, pos_ff, Pw'(1), 8'd0);
               nres = nres + 2'd1;
            end
            sqltl_pkg::CH_LT:    mode_in = sqltl_pkg::M_LT;
            sqltl_pkg::CH_GT:    mode_in = sqltl_pkg::M_GT;
            sqltl_pkg::CH_BANG:  mode_in = sqltl_pkg::M_BANG;
            sqltl_pkg::CH_MINUS: mode_in = sqltl_pkg::M_MINUS;
            sqltl_pkg::CH_QUOTE: mode_in = sqltl_pkg::M_STRING;
            default: begin
               if (is_dig) begin
                  mode_in = sqltl_pkg::M_NUMBER;
                  neg_in  = 1'b0;
                  ovf_in  = 1'b0;
                  acc_in  = '0;
                  add_en  = 1'b1;
               end else if (is_alpha || b == sqltl_pkg::CH_UNDER) begin
                  mode_in = sqltl_pkg::M_WORD;
                  wbuf_in = {48'd0, ub};
                  wlen_in = 4'd1;
               end else begin
                  res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_ERROR, pos_ff, Pw'(1), b);
                  nres = nres + 2'd1;
               end
            end
         endcase
      end

      // acc*10 + digit against the saturation limit
      if (add_en && !ovf_in) begin
         lim = neg_in ? sqltl_pkg::NumLimNeg : sqltl_pkg::NumLimPos;
         acc_x10 = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {64'd0, b[3:0]};
         if (acc_x10 > {4'd0, lim}) begin
            ovf_in = 1'b1;
            acc_in = lim;
         end else begin
            acc_in = acc_x10[63:0];
         end
      end

      if (req_chan.in_last) begin
         if (mode_in != sqltl_pkg::M_IDLE) begin
            res[nres] = sqltl_pkg::finish_item(mode_in, tstart_in, p1, acc_in, neg_in,
                                               ovf_in, wbuf_in, wlen_in);
            nres = nres + 2'd1;
         end
         res[nres] = sqltl_pkg::mk_item(sqltl_pkg::K_END, p1, Pw'(0), 8'd0);
         nres = nres + 2'd1;
         mode_in   = sqltl_pkg::M_IDLE;
         pos_in    = '0;
         tstart_in = '0;
         wbuf_in   = '0;
         wlen_in   = '0;
         acc_in    = '0;
         neg_in    = 1'b0;
         ovf_in    = 1'b0;
      end else begin
         pos_in = p1;
      end

      if (nres != 2'd0) begin
         res[nres - 2'd1].last_of_run = 1'b1;
      end
   end

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (take) begin
         wptr_in  = wptr_ff + Aw'(nres);
         count_in = count_in + (Aw+1)'(nres);
      end
      if (give) begin
         rptr_in  = rptr_ff + Aw'(1);
         count_in = count_in - (Aw+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= sqltl_pkg::M_IDLE;
         pos_ff    <= '0;
         tstart_ff <= '0;
         wbuf_ff   <= '0;
         wlen_ff   <= '0;
         acc_ff    <= '0;
         neg_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (take) begin
            mode_ff   <= mode_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
            wbuf_ff   <= wbuf_in;
            wlen_ff   <= wlen_in;
            acc_ff    <= acc_in;
            neg_ff    <= neg_in;
            ovf_ff    <= ovf_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < sqltl_pkg::MaxResults; i++) begin
            if (i < int'(nres)) begin
               queue_ff[wptr_ff + Aw'(i)] <= res[i];
            end
         end
      end
   end

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.kind         = queue_ff[rptr_ff].kind;
   assign rsp_chan.start_pos    = queue_ff[rptr_ff].start_pos;
   assign rsp_chan.span_len     = queue_ff[rptr_ff].span_len;
   assign rsp_chan.num_value    = queue_ff[rptr_ff].num_value;
   assign rsp_chan.num_overflow = queue_ff[rptr_ff].num_overflow;
   assign rsp_chan.char_out     = queue_ff[rptr_ff].char_out;
   assign rsp_chan.last_of_run  = queue_ff[rptr_ff].last_of_run;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Testbench for sql_token_lexer_unit: directed and random query text, with
// a token predictor in the bench and an in-order check of every token item.
// Depends on sqltl_pkg and the channel interfaces in sqltl_if.sv.
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   sqltl_req_if req_chan ();
   sqltl_rsp_if rsp_chan ();

   sql_token_lexer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // lexer state kept by the predictor
   logic [3:0]  lx_mode;
   logic [15:0] lx_pos, lx_tstart, lx_wlen;
   logic [55:0] lx_wbuf;
   logic [63:0] lx_acc;
   logic        lx_neg, lx_ovf;

   sqltl_pkg::result_type token_q[$];
   int          step_count;
   int          fail_count = 0;
   int          token_count = 0;
   int          byte_count = 0;

   string kw_text[32] = '{"CREATE", "TABLE", "INSERT", "INTO", "VALUES", "SELECT", "FROM",
      "WHERE", "AND", "OR", "NOT", "DELETE", "DROP", "INDEX", "ON", "ORDER", "BY", "ASC",
      "DESC", "SET", "UPDATE", "INT", "INTEGER", "VARCHAR", "TEXT", "BOOL", "BOOLEAN",
      "TRUE", "FALSE", "NULL", "PRIMARY", "KEY"};
   int kw_code[32] = '{16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 32,
      33, 34, 35, 36, 37, 37, 38, 39, 40, 40, 41, 42, 43, 44, 45};

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
   endfunction

   function automatic void lexer_clear();
      lx_mode = sqltl_pkg::M_IDLE;
      lx_pos = '0;
      lx_tstart = '0;
      lx_wbuf = '0;
      lx_wlen = '0;
      lx_acc = '0;
      lx_neg = 1'b0;
      lx_ovf = 1'b0;
   endfunction

   function automatic void emit(logic [5:0] kind, logic [15:0] start, logic [15:0] span,
                                logic [63:0] val, logic ovf, logic [7:0] ch);
      sqltl_pkg::result_type r;
      r = '0;
      r.kind = kind;
      r.start_pos = start;
      r.span_len = span;
      r.num_value = val;
      r.num_overflow = ovf;
      r.char_out = ch;
      token_q = {token_q, r};
      step_count++;
   endfunction

   function automatic logic [5:0] word_code();
      bit hit;
      if (lx_wlen > 16'd7) return sqltl_pkg::K_IDENT;
      for (int i = 0; i < 32; i++) begin
         if (kw_text[i].len() == int'(lx_wlen)) begin
            hit = 1'b1;
            for (int j = 0; j < kw_text[i].len(); j++) begin
               if (lx_wbuf[8*j +: 8] != kw_text[i][j]) hit = 1'b0;
            end
            if (hit) return 6'(kw_code[i]);
         end
      end
      return sqltl_pkg::K_IDENT;
   endfunction

   function automatic void close_token(logic [15:0] end_p);
      logic [15:0] span;
      span = end_p - lx_tstart;
      case (lx_mode)
         sqltl_pkg::M_LT:     emit(sqltl_pkg::K_LT, lx_tstart, span, '0, 1'b0, 8'd0);
         sqltl_pkg::M_GT:     emit(sqltl_pkg::K_GT, lx_tstart, span, '0, 1'b0, 8'd0);
         sqltl_pkg::M_BANG:   emit(sqltl_pkg::K_ERROR, lx_tstart, span, '0, 1'b0,
                                   sqltl_pkg::CH_BANG);
         sqltl_pkg::M_MINUS:  emit(sqltl_pkg::K_ERROR, lx_tstart, span, '0, 1'b0,
                                   sqltl_pkg::CH_MINUS);
         sqltl_pkg::M_NUMBER: emit(sqltl_pkg::K_NUMBER, lx_tstart, span,
                                   lx_neg ? ~lx_acc + 64'd1 : lx_acc, lx_ovf, 8'd0);
         sqltl_pkg::M_WORD:   emit(word_code(), lx_tstart, span, '0, 1'b0, 8'd0);
         sqltl_pkg::M_STRING, sqltl_pkg::M_ESC:
            emit(sqltl_pkg::K_STRING, lx_tstart, span, '0, 1'b0, 8'd0);
         default: ;
      endcase
      lx_mode = sqltl_pkg::M_IDLE;
   endfunction

   function automatic void add_digit(logic [7:0] b);
      logic [63:0] d, lim;
      d = 64'(b - "0");
      lim = lx_neg ? sqltl_pkg::NumLimNeg : sqltl_pkg::NumLimPos;
      if (lx_ovf) return;
      if (lx_acc > (lim - d) / 64'd10) begin
         lx_ovf = 1'b1;
         lx_acc = lim;
      end else begin
         lx_acc = lx_acc * 64'd10 + d;
      end
   endfunction

   function automatic void open_token(logic [7:0] b, logic [15:0] p);
      lx_tstart = p;
      case (b)
         sqltl_pkg::CH_SPACE, sqltl_pkg::CH_TAB, sqltl_pkg::CH_LF, sqltl_pkg::CH_CR: ;
         sqltl_pkg::CH_STAR:   emit(sqltl_pkg::K_STAR, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_LPAREN: emit(sqltl_pkg::K_LPAREN, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_RPAREN: emit(sqltl_pkg::K_RPAREN, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_COMMA:  emit(sqltl_pkg::K_COMMA, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_SEMI:   emit(sqltl_pkg::K_SEMI, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_EQ:     emit(sqltl_pkg::K_EQ, p, 16'd1, '0, 1'b0, 8'd0);
         sqltl_pkg::CH_LT:     lx_mode = sqltl_pkg::M_LT;
         sqltl_pkg::CH_GT:     lx_mode = sqltl_pkg::M_GT;
         sqltl_pkg::CH_BANG:   lx_mode = sqltl_pkg::M_BANG;
         sqltl_pkg::CH_MINUS:  lx_mode = sqltl_pkg::M_MINUS;
         sqltl_pkg::CH_QUOTE:  lx_mode = sqltl_pkg::M_STRING;
         default: begin
            if (is_digit(b)) begin
               lx_mode = sqltl_pkg::M_NUMBER;
               lx_neg = 1'b0;
               lx_ovf = 1'b0;
               lx_acc = '0;
               add_digit(b);
            end else if (is_alpha(b) || b == sqltl_pkg::CH_UNDER) begin
               lx_mode = sqltl_pkg::M_WORD;
               lx_wbuf = 56'(to_upper(b));
               lx_wlen = 16'd1;
            end else begin
               emit(sqltl_pkg::K_ERROR, p, 16'd1, '0, 1'b0, b);
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(logic [7:0] b, logic last);
      logic [15:0] p;
      p = lx_pos;
      step_count = 0;
      case (lx_mode)
         sqltl_pkg::M_LT: begin
            if (b == sqltl_pkg::CH_EQ) begin
               emit(sqltl_pkg::K_LE, lx_tstart, 16'd2, '0, 1'b0, 8'd0);
               lx_mode = sqltl_pkg::M_IDLE;
            end else if (b == sqltl_pkg::CH_GT) begin
               emit(sqltl_pkg::K_NE, lx_tstart, 16'd2, '0, 1'b0, 8'd0);
               lx_mode = sqltl_pkg::M_IDLE;
            end else begin
               close_token(p);
               open_token(b, p);
            end
         end
         sqltl_pkg::M_GT, sqltl_pkg::M_BANG: begin
            if (b == sqltl_pkg::CH_EQ) begin
               emit(lx_mode == sqltl_pkg::M_GT ? sqltl_pkg::K_GE : sqltl_pkg::K_NE,
                    lx_tstart, 16'd2, '0, 1'b0, 8'd0);
               lx_mode = sqltl_pkg::M_IDLE;
            end else begin
               close_token(p);
               open_token(b, p);
            end
         end
         sqltl_pkg::M_MINUS: begin
            if (is_digit(b)) begin
               lx_mode = sqltl_pkg::M_NUMBER;
               lx_neg = 1'b1;
               lx_ovf = 1'b0;
               lx_acc = '0;
               add_digit(b);
            end else begin
               close_token(p);
               open_token(b, p);
            end
         end
         sqltl_pkg::M_NUMBER: begin
            if (is_digit(b)) add_digit(b);
            else begin
               close_token(p);
               open_token(b, p);
            end
         end
         sqltl_pkg::M_WORD: begin
            if (is_alpha(b) || is_digit(b) || b == sqltl_pkg::CH_UNDER) begin
               if (lx_wlen < 16'd7) lx_wbuf[8*lx_wlen[2:0] +: 8] = to_upper(b);
               if (lx_wlen != 16'hFFFF) lx_wlen++;
            end else begin
               close_token(p);
               open_token(b, p);
            end
         end
         sqltl_pkg::M_STRING: begin
            if (b == sqltl_pkg::CH_QUOTE) close_token(p + 16'd1);
            else if (b == sqltl_pkg::CH_BSLASH) lx_mode = sqltl_pkg::M_ESC;
            else emit(sqltl_pkg::K_CONTENT, p, 16'd1, '0, 1'b0, b);
         end
         sqltl_pkg::M_ESC: begin
            emit(sqltl_pkg::K_CONTENT, p - 16'd1, 16'd2, '0, 1'b0, b);
            lx_mode = sqltl_pkg::M_STRING;
         end
         default: open_token(b, p);
      endcase
      if (last) begin
         if (lx_mode != sqltl_pkg::M_IDLE) close_token(p + 16'd1);
         emit(sqltl_pkg::K_END, p + 16'd1, 16'd0, '0, 1'b0, 8'd0);
         lexer_clear();
      end else begin
         lx_pos = p + 16'd1;
      end
      if (step_count > 0) token_q[$].last_of_run = 1'b1;
   endfunction

   // sender: valid stays high between back-to-back items
   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      lex_byte(b, last);
      byte_count++;
   endtask

   task automatic send_text(string s, bit close_query);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], close_query && i == s.len() - 1);
      end
   endtask

   task automatic wait_drained();
      while (token_q.size() != 0) @(posedge clock);
   endtask

   // receiver with random stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.ready && rsp_chan.valid) begin
         stall_left = $urandom_range(0, 18);
         if ($urandom_range(0, 2) == 0) stall_left = 0;
         rsp_chan.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= (stall_left == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sqltl_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         token_count++;
         if (token_q.size() == 0) begin
            $display("%0t: token item with none expected, kind %0d", $time, rsp_chan.kind);
            fail_count++;
         end else begin
            want = token_q.pop_front();
            if (rsp_chan.kind !== want.kind || rsp_chan.start_pos !== want.start_pos ||
                rsp_chan.span_len !== want.span_len || rsp_chan.num_value !== want.num_value ||
                rsp_chan.num_overflow !== want.num_overflow ||
                rsp_chan.char_out !== want.char_out ||
                rsp_chan.last_of_run !== want.last_of_run) begin
               $display("%0t: mismatch expected kind %0d pos %0d span %0d val %0d ovf %0b ch %h last %0b",
                        $time, want.kind, want.start_pos, want.span_len, want.num_value,
                        want.num_overflow, want.char_out, want.last_of_run);
               $display("%0t:          actual kind %0d pos %0d span %0d val %0d ovf %0b ch %h last %0b",
                        $time, rsp_chan.kind, rsp_chan.start_pos, rsp_chan.span_len,
                        rsp_chan.num_value, rsp_chan.num_overflow, rsp_chan.char_out,
                        rsp_chan.last_of_run);
               fail_count++;
            end
         end
      end
   end

   task automatic test_symbols();
      send_text("select *,(a)<=b<>c>=d!=e;x<y>z=1 ", 1'b1);
   endtask

   task automatic test_numbers();
      send_text("9223372036854775807 -9223372036854775808 99999999999999999999", 1'b0);
      send_text(" -99999999999999999999 -0", 1'b1);
   endtask

   task automatic test_errors();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_text("!a -b # ! -", 1'b1);
   endtask

   task automatic test_strings();
      send_text("'ab\\'c' 'x\\", 1'b1);
      send_text("'open", 1'b1);
      send_text("IntegeR boolean primarykey Key_1 _", 1'b1);
   endtask

   task automatic test_random();
      string frag;
      string piece;
      int sent;
      sent = 0;
      while (sent < 80) begin
         case ($urandom_range(0, 9))
            0: piece = kw_text[$urandom_range(0, 31)];
            1: piece = $sformatf("%0d", $urandom);
            2: piece = $sformatf("-%0d%0d", $urandom, $urandom);
            3: piece = "'s\\'q x'";
            4: piece = "<";
            5: piece = "!=";
            6: piece = ">=";
            7: piece = "( * ) , ;";
            8: piece = "col_9";
            default: piece = "";
         endcase
         frag = piece;
         for (int i = 0; i < frag.len(); i++) begin
            if ($urandom_range(0, 1) && is_alpha(frag[i])) frag[i] = frag[i] ^ 8'h20;
         end
         if (piece == "") begin
            send_byte(8'($urandom), 1'b0);
            sent++;
         end else begin
            send_text(frag, 1'b0);
            sent += frag.len();
         end
         if ($urandom_range(0, 9) == 0) send_byte(sqltl_pkg::CH_SPACE, 1'($urandom_range(0, 1)));
         else send_byte(sqltl_pkg::CH_SPACE, 1'b0);
         sent++;
         if (sent > 40 && sent < 50) begin
            req_chan.valid <= 1'b0;
            wait_drained();
            sent = 50;
         end
      end
      send_byte(";", 1'b1);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.in_byte = 8'd0;
      req_chan.in_last = 1'b0;
      lexer_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_symbols();
      test_numbers();
      test_errors();
      test_strings();
      test_random();
      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      $display("Lexed %0d query bytes into %0d token items: symbols, numbers at the limits,",
               byte_count, token_count);
      $display("strings with escapes, keywords, errors and random queries.");
      if (fail_count == 0 && token_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
